// ===== rtl/core/dqs_pkg.sv =====
// Package for the bounded deque with search: sizes, request and status codes,
// and the per-cell control struct.
// No dependencies.
`timescale 1ns / 1ps

package dqs_pkg;

  // Store geometry
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int POS_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // Request codes
  localparam logic [2:0] REQ_PUSH_BACK  = 3'd0;
  localparam logic [2:0] REQ_PUSH_FRONT = 3'd1;
  localparam logic [2:0] REQ_POP_BACK   = 3'd2;
  localparam logic [2:0] REQ_POP_FRONT  = 3'd3;
  localparam logic [2:0] REQ_FIND       = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Control for one cell of the chain
  typedef struct packed {
    logic shift_right;  // push front: take the left neighbour's entry
    logic shift_left;   // pop front: take the right neighbour's entry
    logic load;         // push back: take the new value
  } cell_ctl_t;

endpackage

// ===== rtl/core/bounded_deque_with_search_core.sv =====
// Top level of the bounded deque with search: a chain of cells ordered from
// the front, an entry counter, first-match encoding and the result register.
// Depends on dqs_pkg and dqs_cell.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  request | in_valid, in_stall, in_req_type, in_value | in (in_stall out)
//  result  | out_valid, out_stall, out_status, out_found,
//          | out_position, out_occupancy               | out (out_stall in)
//
// The cells shift or compare in the cycle of acceptance and the result is
// registered, so one transaction per cycle while the request side is not
// stalled. The combinational path is the key compare in every cell followed
// by the first-match encoder. Reset empties the deque (count and result
// valid cleared); cell contents are not reset. A stalled result holds the
// register and the request side is stalled only while that result waits.
`timescale 1ns / 1ps

module bounded_deque_with_search_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_req_type,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic               out_found,
  output logic [3:0]         out_position,
  output logic [4:0]         out_occupancy
);
  import dqs_pkg::*;

  logic                  accept;
  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      count_nxt;
  logic                  is_full;
  logic                  is_empty;
  logic [DATA_WIDTH-1:0] key;

  cell_ctl_t             ctl [DEPTH];
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]      hits;
  logic [DEPTH-1:0]      first_hot;
  logic [POS_W-1:0]      match_pos;

  logic                  out_valid_r;
  logic [1:0]            status_r;
  logic [1:0]            status_nxt;
  logic                  found_r;
  logic                  found_nxt;
  logic [3:0]            position_r;
  logic [3:0]            position_nxt;
  logic [4:0]            occupancy_r;

  // Handshake: a waiting result blocks only while it is stalled
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign key      = in_value[DATA_WIDTH-1:0];
  assign is_full  = (count_r == CNT_W'(DEPTH));
  assign is_empty = (count_r == '0);

  // Per-cell control
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ctl[i].shift_right = accept && (in_req_type == REQ_PUSH_FRONT) && !is_full;
      ctl[i].shift_left  = accept && (in_req_type == REQ_POP_FRONT) && !is_empty;
      ctl[i].load        = accept && (in_req_type == REQ_PUSH_BACK) && !is_full
                           && (count_r == CNT_W'(i));
    end
  end

  // Chain of cells, cell 0 is the front
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_d;
    logic [DATA_WIDTH-1:0] right_d;

    if (g == 0) begin : g_first
      assign left_d = key;
    end else begin : g_mid_l
      assign left_d = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_d = cell_data[g];
    end else begin : g_mid_r
      assign right_d = cell_data[g+1];
    end

    dqs_cell u_cell (
      .clk        (clk),
      .ctl        (ctl[g]),
      .left_data  (left_d),
      .right_data (right_d),
      .new_data   (key),
      .occupied   (count_r > CNT_W'(g)),
      .data       (cell_data[g]),
      .hit        (hits[g])
    );
  end

  // First match: isolate lowest hit, then encode it
  assign first_hot = hits & (~hits + DEPTH'(1));

  always_comb begin
    match_pos = '0;
    for (int b = 0; b < POS_W; b++) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (((i >> b) & 1) == 1) begin
          match_pos[b] = match_pos[b] | first_hot[i];
        end
      end
    end
  end

  // Result and counter update
  always_comb begin
    status_nxt   = ST_OK;
    found_nxt    = 1'b0;
    position_nxt = '0;
    count_nxt    = count_r;
    case (in_req_type)
      REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
        if (is_full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      REQ_POP_BACK, REQ_POP_FRONT: begin
        if (is_empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      REQ_FIND: begin
        if (is_empty) begin
          status_nxt = ST_EMPTY;
        end else if (|hits) begin
          found_nxt    = 1'b1;
          position_nxt = 4'(match_pos);
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r    <= status_nxt;
      found_r     <= found_nxt;
      position_r  <= position_nxt;
      occupancy_r <= 5'(count_nxt);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_found     = found_r;
  assign out_position  = position_r;
  assign out_occupancy = occupancy_r;

endmodule

// ===== rtl/core/dqs_cell.sv =====
// One cell of the deque chain: holds one entry, shifts to either side or
// loads a new one, and compares its entry with the search key.
// Depends on dqs_pkg.
`timescale 1ns / 1ps

module dqs_cell (
  input  logic                             clk,
  input  dqs_pkg::cell_ctl_t               ctl,
  input  logic [dqs_pkg::DATA_WIDTH-1:0]   left_data,
  input  logic [dqs_pkg::DATA_WIDTH-1:0]   right_data,
  input  logic [dqs_pkg::DATA_WIDTH-1:0]   new_data,
  input  logic                             occupied,
  output logic [dqs_pkg::DATA_WIDTH-1:0]   data,
  output logic                             hit
);
  import dqs_pkg::*;

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  // Next entry: shift, load or hold
  always_comb begin
    data_nxt = data_r;
    if (ctl.shift_right) begin
      data_nxt = left_data;
    end else if (ctl.shift_left) begin
      data_nxt = right_data;
    end else if (ctl.load) begin
      data_nxt = new_data;
    end
  end

  // Entry payload, no reset needed
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;
  assign hit  = occupied && (data_r == new_data);

endmodule
